// ===== rtl/core/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the source token lexer
// Lexer modes, token kinds, the keyword table and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

  localparam int unsigned MAX_TEXT_BYTES_DEF  = 65536;
  localparam int unsigned KEYWORD_MAX_LEN_DEF = 6;

  // result queue between the lexer and the output port (power of two)
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned KIND_W = 6;
  localparam int unsigned POS_W  = 16;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_FRAC,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_PENDOP
  } mode_t;

  localparam logic [KIND_W-1:0] K_IDENT   = 6'd0;
  localparam logic [KIND_W-1:0] K_NUMBER  = 6'd1;
  localparam logic [KIND_W-1:0] K_COMMENT = 6'd2;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd3;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd4;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd5;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd6;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd7;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd8;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd9;
  localparam logic [KIND_W-1:0] K_DOT     = 6'd10;
  localparam logic [KIND_W-1:0] K_COLON   = 6'd11;
  localparam logic [KIND_W-1:0] K_SEMI    = 6'd12;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd13;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd14;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd15;
  localparam logic [KIND_W-1:0] K_LT      = 6'd17;
  localparam logic [KIND_W-1:0] K_GT      = 6'd19;
  localparam logic [KIND_W-1:0] K_AMP     = 6'd21;
  localparam logic [KIND_W-1:0] K_KW0     = 6'd23;
  localparam logic [KIND_W-1:0] K_ERROR   = 6'd33;
  localparam logic [KIND_W-1:0] K_END     = 6'd34;

  localparam int unsigned KW_COUNT    = 10;
  localparam int unsigned KW_TEXT_MAX = 6;

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd6, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd6
  };

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_MAX] = '{
    '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00},
    '{"n", "u", "m", "b", "e", "r"},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"b", "r", "e", "a", "k", 8'h00},
    '{"r", "e", "t", "u", "r", "n"}
  };

  // one token as the lexer produces it
  typedef struct packed {
    logic              vld;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
  } tok_t;

  // one queued result transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic              last_of_run;
    logic              end_of_text;
  } res_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_white(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_pend_op(logic [7:0] c);
    return c == "=" || c == "<" || c == ">" || c == "&";
  endfunction

  // single-character kind of a pending operator
  function automatic logic [KIND_W-1:0] op_single(logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      "=":     k = K_ASSIGN;
      "<":     k = K_LT;
      ">":     k = K_GT;
      default: k = K_AMP;
    endcase
    return k;
  endfunction

  // kind of a byte that forms a token on its own
  function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "*":     k = K_STAR;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      ",":     k = K_COMMA;
      ".":     k = K_DOT;
      ":":     k = K_COLON;
      ";":     k = K_SEMI;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stl_lexer.sv =====
// ----------------------------------------------------------------------------
// stl_lexer: lexer state and per-byte token logic
// Takes one byte per step and produces up to two tokens in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_lexer #(
  parameter int unsigned MAX_TEXT_BYTES  = stl_pkg::MAX_TEXT_BYTES_DEF,
  parameter int unsigned KEYWORD_MAX_LEN = stl_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   text_byte,
  input  wire logic         final_byte,
  input  wire logic         emit_comments,
  output stl_pkg::res_t     res0,
  output stl_pkg::res_t     res1,
  output logic [1:0]        res_cnt
);

  import stl_pkg::*;

  localparam int unsigned KW_IW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [POS_W-1:0] POS_CAP =
    (MAX_TEXT_BYTES - 1 > 65535) ? 16'hFFFF : POS_W'(MAX_TEXT_BYTES - 1);

  typedef logic [7:0] kwbuf_t [KEYWORD_MAX_LEN];

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] tb_r, tb_nxt;
  logic [7:0]       pend_r, pend_nxt;
  kwbuf_t           kw_r, kw_nxt;

  // length from token begin up to (not including) end, saturating
  function automatic logic [POS_W-1:0] span_len(logic [POS_W:0] fin_end,
                                                logic [POS_W-1:0] tb);
    logic [POS_W:0] d;
    d = fin_end - {1'b0, tb};
    if (fin_end <= {1'b0, tb}) return '0;
    if (d[POS_W]) return '1;
    return d[POS_W-1:0];
  endfunction

  function automatic logic [KIND_W-1:0] ident_kind(logic [POS_W-1:0] len, kwbuf_t kw);
    logic [KIND_W-1:0] kind;
    logic              hit;
    kind = K_IDENT;
    if (len <= POS_W'(KEYWORD_MAX_LEN)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        hit = (len == POS_W'(KW_LEN[i]));
        for (int j = 0; j < KW_TEXT_MAX; j++) begin
          if (j < KW_LEN[i] && kw[KW_IW'(j)] != KW_TEXT[i][j]) hit = 1'b0;
        end
        if (hit && kind == K_IDENT) kind = K_KW0 + KIND_W'(i);
      end
    end
    return kind;
  endfunction

  // token left open in mode m, closed at offset fin_end
  function automatic tok_t finish_tok(mode_t m, logic [POS_W-1:0] tb,
                                      logic [POS_W:0] fin_end, logic [7:0] pend,
                                      kwbuf_t kw, logic emit_c);
    tok_t t;
    t = '0;
    t.start = tb;
    unique case (m)
      MODE_IDENT: begin
        t.vld  = 1'b1;
        t.len  = span_len(fin_end, tb);
        t.kind = ident_kind(t.len, kw);
      end
      MODE_INT, MODE_FRAC: begin
        t.vld  = 1'b1;
        t.kind = K_NUMBER;
        t.len  = span_len(fin_end, tb);
      end
      MODE_SLASH: begin
        t.vld  = 1'b1;
        t.kind = K_SLASH;
        t.len  = POS_W'(1);
      end
      MODE_PENDOP: begin
        t.vld  = 1'b1;
        t.kind = op_single(pend);
        t.len  = POS_W'(1);
      end
      MODE_COMMENT: begin
        t.vld  = emit_c;
        t.kind = K_COMMENT;
        t.len  = span_len(fin_end, tb);
      end
      default: t.vld = 1'b0;
    endcase
    return t;
  endfunction

  always_comb begin
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] k_off;
    logic             taken;
    logic [7:0]       second;
    mode_t            mode1;
    tok_t             t1, t2, t3;
    tok_t             r0, r1;
    logic             fin_any;

    pos_inc  = {1'b0, pos_r} + 1'b1;
    k_off    = pos_r - tb_r;
    taken    = 1'b0;
    mode1    = mode_r;
    t1       = '0;
    t2       = '0;
    t3       = '0;
    kw_nxt   = kw_r;
    tb_nxt   = tb_r;
    pend_nxt = pend_r;
    second   = (pend_r == "&") ? 8'("&") : 8'("=");

    // continue or close the open token
    unique case (mode_r)
      MODE_IDENT: begin
        if (is_alpha(text_byte) || is_digit(text_byte)) begin
          taken = 1'b1;
          if (pos_r >= tb_r && k_off < POS_W'(KEYWORD_MAX_LEN))
            kw_nxt[k_off[KW_IW-1:0]] = text_byte;
        end else begin
          t1    = finish_tok(mode_r, tb_r, {1'b0, pos_r}, pend_r, kw_r, emit_comments);
          mode1 = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (is_digit(text_byte)) begin
          taken = 1'b1;
        end else if (text_byte == ".") begin
          taken = 1'b1;
          mode1 = MODE_FRAC;
        end else begin
          t1    = finish_tok(mode_r, tb_r, {1'b0, pos_r}, pend_r, kw_r, emit_comments);
          mode1 = MODE_IDLE;
        end
      end
      MODE_FRAC: begin
        if (is_digit(text_byte)) begin
          taken = 1'b1;
        end else begin
          t1    = finish_tok(mode_r, tb_r, {1'b0, pos_r}, pend_r, kw_r, emit_comments);
          mode1 = MODE_IDLE;
        end
      end
      MODE_SLASH: begin
        if (text_byte == "/") begin
          taken = 1'b1;
          mode1 = MODE_COMMENT;
        end else begin
          t1    = finish_tok(mode_r, tb_r, {1'b0, pos_r}, pend_r, kw_r, emit_comments);
          mode1 = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (text_byte == 8'h0A) begin
          t1    = finish_tok(mode_r, tb_r, {1'b0, pos_r}, pend_r, kw_r, emit_comments);
          mode1 = MODE_IDLE;
        end else begin
          taken = 1'b1;
        end
      end
      MODE_PENDOP: begin
        if (text_byte == second) begin
          taken    = 1'b1;
          t1.vld   = 1'b1;
          t1.kind  = op_single(pend_r) + KIND_W'(1);
          t1.start = tb_r;
          t1.len   = POS_W'(2);
          mode1    = MODE_IDLE;
        end else begin
          t1    = finish_tok(mode_r, tb_r, {1'b0, pos_r}, pend_r, kw_r, emit_comments);
          mode1 = MODE_IDLE;
        end
      end
      default: mode1 = MODE_IDLE;
    endcase

    // start a new token, or emit a one-byte token
    mode_nxt = mode1;
    if (!taken && !is_white(text_byte)) begin
      priority if (is_alpha(text_byte)) begin
        mode_nxt  = MODE_IDENT;
        tb_nxt    = pos_r;
        kw_nxt[0] = text_byte;
      end else if (is_digit(text_byte)) begin
        mode_nxt = MODE_INT;
        tb_nxt   = pos_r;
      end else if (text_byte == "/") begin
        mode_nxt = MODE_SLASH;
        tb_nxt   = pos_r;
      end else if (is_pend_op(text_byte)) begin
        mode_nxt = MODE_PENDOP;
        tb_nxt   = pos_r;
        pend_nxt = text_byte;
      end else begin
        t2.vld   = 1'b1;
        t2.kind  = single_kind(text_byte);
        t2.start = pos_r;
        t2.len   = POS_W'(1);
      end
    end

    // end of buffer: flush, or end marker if nothing else came out
    if (final_byte) begin
      t3 = finish_tok(mode_nxt, tb_nxt, pos_inc, pend_nxt, kw_nxt, emit_comments);
      if (!t1.vld && !t2.vld && !t3.vld) begin
        t3.vld   = 1'b1;
        t3.kind  = K_END;
        t3.start = pos_inc[POS_W] ? '1 : pos_inc[POS_W-1:0];
        t3.len   = '0;
      end
    end

    // pack in order
    r1 = '0;
    priority if (t1.vld) begin
      r0 = t1;
      r1 = t2.vld ? t2 : t3;
    end else if (t2.vld) begin
      r0 = t2;
      r1 = t3;
    end else begin
      r0 = t3;
    end

    fin_any = r0.vld || r1.vld;
    res_cnt = {1'b0, r0.vld} + {1'b0, r1.vld};
    res0    = '{kind: r0.kind, start: r0.start, len: r0.len,
                last_of_run: !r1.vld, end_of_text: final_byte && !r1.vld};
    res1    = '{kind: r1.kind, start: r1.start, len: r1.len,
                last_of_run: 1'b1, end_of_text: final_byte && fin_any};

    if (final_byte) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = (pos_inc > {1'b0, POS_CAP}) ? POS_CAP : pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      tb_r   <= '0;
      pend_r <= '0;
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) kw_r[i] <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      if (final_byte) begin
        mode_r <= MODE_IDLE;
        tb_r   <= '0;
        pend_r <= '0;
        for (int i = 0; i < KEYWORD_MAX_LEN; i++) kw_r[i] <= '0;
      end else begin
        mode_r <= mode_nxt;
        tb_r   <= tb_nxt;
        pend_r <= pend_nxt;
        kw_r   <= kw_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stl_fifo.sv =====
// ----------------------------------------------------------------------------
// stl_fifo: result queue
// Takes up to two results per cycle, hands out one per cycle on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_fifo (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic [1:0]                              push_cnt,
  input  wire stl_pkg::res_t                           din0,
  input  wire stl_pkg::res_t                           din1,
  input  wire logic                                    pop,
  output stl_pkg::res_t                                head,
  output logic [$clog2(stl_pkg::FIFO_DEPTH + 1)-1:0]   cnt
);

  import stl_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  res_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_r] <= din0;
    if (push_cnt == 2'd2) mem_r[wr_r + PW'(1)] <= din1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PW'(push_cnt);
      rd_r  <= rd_r + PW'(pop);
      cnt_r <= cnt_r + CW'(push_cnt) - CW'(pop);
    end
  end

  assign head = mem_r[rd_r];
  assign cnt  = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/source_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// source_token_lexer_unit: byte-stream source lexer
// Splits source text into identifier, number, comment, operator and keyword
// tokens, one input byte per transaction, up to two tokens per byte.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_stall  | in_text_byte, in_final_byte
//   out     | output    | out_valid / out_stall| out_token_kind/_start/_length,
//           |           |                      | out_last_of_run, out_end_of_text
//   cfg     | input     | cfg_valid / cfg_ready| cfg_emit_comments
//
// One byte per cycle enters while in_stall is low. A byte waits in the input
// register until the queue has room, then the lexer writes its tokens into a
// 4-entry result queue, from whose head the first token reaches the port.
// The output drains one token per cycle unless stalled, so bytes that yield
// two tokens set the sustained rate: the queue must have room for two before
// a byte moves on. Reset (rst_n low, synchronous) empties the queue and the
// input register, puts the lexer between tokens at offset 0 and clears
// emit_comments. out_stall backs up into the queue and then into in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module source_token_lexer_unit #(
  parameter int unsigned MAX_TEXT_BYTES  = stl_pkg::MAX_TEXT_BYTES_DEF,
  parameter int unsigned KEYWORD_MAX_LEN = stl_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // source bytes
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_final_byte,
  // tokens
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_last_of_run,
  output logic             out_end_of_text,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_emit_comments
);

  import stl_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic          stage_vld_r;
  logic [7:0]    stage_byte_r;
  logic          stage_fin_r;
  logic          emit_cmt_r;

  logic          advance;
  logic          pop;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_after_pop;
  logic [1:0]    res_cnt;
  res_t          res0, res1, head;

  // the user must write config only between buffers, unchecked here; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cmt_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      emit_cmt_r <= cfg_emit_comments;
    end
  end

  // output side: a token leaves the queue head on each completed transaction
  assign pop           = out_valid && !out_stall;
  assign cnt_after_pop = cnt - CW'(pop);

  // a byte is lexed only when the queue can absorb both of its tokens
  assign advance  = stage_vld_r && (cnt_after_pop <= CW'(FIFO_DEPTH - 2));
  assign in_stall = stage_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_vld_r <= 1'b1;
    end else if (advance) begin
      stage_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_byte_r <= in_text_byte;
      stage_fin_r  <= in_final_byte;
    end
  end

  stl_lexer #(
    .MAX_TEXT_BYTES  (MAX_TEXT_BYTES),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_lexer (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .text_byte     (stage_byte_r),
    .final_byte    (stage_fin_r),
    .emit_comments (emit_cmt_r),
    .res0          (res0),
    .res1          (res1),
    .res_cnt       (res_cnt)
  );

  stl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (advance ? res_cnt : 2'd0),
    .din0     (res0),
    .din1     (res1),
    .pop      (pop),
    .head     (head),
    .cnt      (cnt)
  );

  assign out_valid        = (cnt != '0);
  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.len;
  assign out_last_of_run  = head.last_of_run;
  assign out_end_of_text  = head.end_of_text;

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CW'(FIFO_DEPTH))
    else $error("result queue over capacity");

  // the last byte of a buffer always yields at least one token
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_fin_r |-> res_cnt != 2'd0)
    else $error("final byte produced no result");

  // end of text only ever marks the last token of a byte
  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_last_of_run)
    else $error("end_of_text without last_of_run");

endmodule

`default_nettype wire

// ===== tb/source_token_lexer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_token_lexer_checker: token predictor and scoreboard
// Watches the byte, token and configuration channels of the lexer, works out
// the tokens each accepted byte must produce and compares every token
// transaction, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------

module source_token_lexer_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_text_byte,
  input  logic              in_final_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [5:0]        out_token_kind,
  input  logic [15:0]       out_token_start,
  input  logic [15:0]       out_token_length,
  input  logic              out_last_of_run,
  input  logic              out_end_of_text,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_emit_comments,
  output int unsigned       pending_tokens,
  output int unsigned       mismatch_count
);

  import stl_pkg::*;

  localparam int unsigned KW_MAX      = 6;
  localparam int unsigned MAX_RESULTS = 2;
  localparam int unsigned POS_LIMIT   =
    (MAX_TEXT_BYTES_DEF - 1 > 65535) ? 65535 : MAX_TEXT_BYTES_DEF - 1;

  string keyword_text [10] = '{"fn", "void", "number", "let", "var",
                               "if", "else", "while", "break", "return"};

  // predictor state
  mode_t       lex_state;
  logic [15:0] cur_pos;
  logic [15:0] tok_start;
  logic [7:0]  kw_buf [KW_MAX];
  logic [7:0]  held_op;
  logic        comments_on;

  res_t        token_fifo [$];
  res_t        run_toks [$];
  int unsigned mismatch_total;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic [KIND_W-1:0] lone_op(input logic [7:0] c);
    if (c == "=") return K_ASSIGN;
    if (c == "<") return K_LT;
    if (c == ">") return K_GT;
    return K_AMP;
  endfunction

  function automatic logic [16:0] span_to(input logic [16:0] stop);
    return (stop > {1'b0, tok_start}) ? stop - {1'b0, tok_start} : 17'd0;
  endfunction

  function automatic logic [KIND_W-1:0] word_kind(input logic [16:0] len);
    logic hit;
    if (len > KW_MAX) return K_IDENT;
    for (int k = 0; k < 10; k++) begin
      if (keyword_text[k].len() == len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (kw_buf[i] != keyword_text[k][i]) hit = 1'b0;
        if (hit) return K_KW0 + KIND_W'(k);
      end
    end
    return K_IDENT;
  endfunction

  task automatic clear_state();
    lex_state = MODE_IDLE;
    cur_pos   = '0;
    tok_start = '0;
    held_op   = '0;
    foreach (kw_buf[i]) kw_buf[i] = '0;
  endtask

  task automatic add_token(input logic [KIND_W-1:0] kind, input logic [15:0] first,
                           input logic [16:0] span);
    res_t t;
    if (run_toks.size() < MAX_RESULTS) begin
      t.kind        = kind;
      t.start       = first;
      t.len         = (span > 17'd65535) ? 16'hFFFF : span[15:0];
      t.last_of_run = 1'b0;
      t.end_of_text = 1'b0;
      run_toks      = {run_toks, t};
    end
  endtask

  task automatic keep_kw_char(input logic [15:0] at, input logic [7:0] c);
    logic [15:0] offs;
    offs = at - tok_start;
    if (at >= tok_start && offs < KW_MAX) kw_buf[offs[2:0]] = c;
  endtask

  // flush the open token, which ends just before offset stop
  task automatic close_token(input logic [16:0] stop);
    logic [16:0] len;
    len = span_to(stop);
    case (lex_state)
      MODE_IDENT:           add_token(word_kind(len), tok_start, len);
      MODE_INT, MODE_FRAC:  add_token(K_NUMBER, tok_start, len);
      MODE_SLASH:           add_token(K_SLASH, tok_start, 17'd1);
      MODE_PENDOP:          add_token(lone_op(held_op), tok_start, 17'd1);
      MODE_COMMENT:         if (comments_on) add_token(K_COMMENT, tok_start, len);
      default: ;
    endcase
    lex_state = MODE_IDLE;
  endtask

  task automatic lex_byte(input logic [7:0] ch, input logic fin);
    logic [15:0]       here;
    logic [16:0]       next_pos;
    logic              used;
    logic [7:0]        pair_second;
    logic [KIND_W-1:0] solo;
    int                last;
    here = cur_pos;
    used = 1'b0;
    run_toks.delete();
    case (lex_state)
      MODE_IDENT: begin
        if (is_letter(ch) || is_num(ch)) begin
          keep_kw_char(here, ch);
          used = 1'b1;
        end else close_token({1'b0, here});
      end
      MODE_INT: begin
        if (is_num(ch)) used = 1'b1;
        else if (ch == ".") begin
          lex_state = MODE_FRAC;
          used = 1'b1;
        end else close_token({1'b0, here});
      end
      MODE_FRAC: begin
        if (is_num(ch)) used = 1'b1;
        else close_token({1'b0, here});
      end
      MODE_SLASH: begin
        if (ch == "/") begin
          lex_state = MODE_COMMENT;
          used = 1'b1;
        end else close_token({1'b0, here});
      end
      MODE_COMMENT: begin
        if (ch == 8'h0A) close_token({1'b0, here});
        else used = 1'b1;
      end
      MODE_PENDOP: begin
        pair_second = (held_op == "&") ? "&" : "=";
        if (ch == pair_second) begin
          add_token(lone_op(held_op) + 1'b1, tok_start, 17'd2);
          lex_state = MODE_IDLE;
          used = 1'b1;
        end else close_token({1'b0, here});
      end
      default: lex_state = MODE_IDLE;
    endcase

    if (!used && !is_space(ch)) begin
      if (is_letter(ch)) begin
        lex_state = MODE_IDENT;
        tok_start = here;
        keep_kw_char(here, ch);
      end else if (is_num(ch)) begin
        lex_state = MODE_INT;
        tok_start = here;
      end else if (ch == "/") begin
        lex_state = MODE_SLASH;
        tok_start = here;
      end else if (ch == "=" || ch == "<" || ch == ">" || ch == "&") begin
        lex_state = MODE_PENDOP;
        tok_start = here;
        held_op   = ch;
      end else begin
        case (ch)
          "(":     solo = K_LPAREN;
          ")":     solo = K_RPAREN;
          "*":     solo = K_STAR;
          "+":     solo = K_PLUS;
          "-":     solo = K_MINUS;
          ",":     solo = K_COMMA;
          ".":     solo = K_DOT;
          ":":     solo = K_COLON;
          ";":     solo = K_SEMI;
          "{":     solo = K_LBRACE;
          "}":     solo = K_RBRACE;
          default: solo = K_ERROR;
        endcase
        add_token(solo, here, 17'd1);
      end
    end

    if (fin) begin
      // lookahead past the end: whatever is open gets flushed
      close_token({1'b0, here} + 17'd1);
      if (run_toks.size() == 0)
        add_token(K_END, (here == 16'hFFFF) ? 16'hFFFF : here + 16'd1, 17'd0);
      last = run_toks.size() - 1;
      run_toks[last].last_of_run = 1'b1;
      run_toks[last].end_of_text = 1'b1;
      clear_state();
    end else begin
      next_pos = {1'b0, here} + 17'd1;
      cur_pos  = (next_pos > POS_LIMIT) ? POS_LIMIT[15:0] : next_pos[15:0];
      if (run_toks.size() > 0) begin
        last = run_toks.size() - 1;
        run_toks[last].last_of_run = 1'b1;
      end
    end
    token_fifo = {token_fifo, run_toks};
  endtask

  task automatic check_field(input string what, input logic [16:0] want_v,
                             input logic [16:0] got_v);
    if (got_v !== want_v) begin
      mismatch_total++;
      $display("%0t ns: token %s mismatch, expected %0d, actual %0d",
               $time, what, want_v, got_v);
    end
  endtask

  task automatic check_token();
    res_t want;
    if (token_fifo.size() == 0) begin
      mismatch_total++;
      $display("%0t ns: unexpected token, expected none, actual kind %0d start %0d len %0d",
               $time, out_token_kind, out_token_start, out_token_length);
    end else begin
      want = token_fifo.pop_front();
      check_field("kind", 17'(want.kind), 17'(out_token_kind));
      check_field("start", 17'(want.start), 17'(out_token_start));
      check_field("length", 17'(want.len), 17'(out_token_length));
      check_field("last_of_run", 17'(want.last_of_run), 17'(out_last_of_run));
      check_field("end_of_text", 17'(want.end_of_text), 17'(out_end_of_text));
    end
  endtask

  initial begin
    mismatch_total = 0;
    comments_on    = 1'b0;
    clear_state();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      comments_on = 1'b0;
      clear_state();
      token_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) comments_on = cfg_emit_comments;
      if (in_valid && !in_stall) lex_byte(in_text_byte, in_final_byte);
      if (out_valid && !out_stall) check_token();
    end
    pending_tokens <= token_fifo.size();
    mismatch_count <= mismatch_total;
  end

endmodule

// ===== tb/source_token_lexer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_token_lexer_unit_test: testbench top of the source token lexer
// Feeds byte buffers into the lexer (a few hand-picked corner buffers, then
// random token-shaped text with noise), stalls the token side at random, and
// takes the verdict from the checker that predicts and compares every token
// transaction.
// ----------------------------------------------------------------------------

module source_token_lexer_unit_test;
  import stl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;    // covers input reg + queue latency
  localparam int unsigned TOKEN_GOAL   = 1000;  // target for bytes sent in total
  localparam int unsigned QUIET_TAIL   = 150;   // no idling over the last bytes
  localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, in cycles

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last_of_run;
  logic        out_end_of_text;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_emit_comments = 1'b0;

  int unsigned tokens_pending;
  int unsigned mismatches;
  int unsigned cycle_count;

  // NBA-driven so the receiver reads them without a race
  logic        steady = 1'b0;      // no idling on either side
  logic        hold_phase = 1'b0;  // arms the receiver's long hold-off

  bit          gaps_on = 1'b1;     // sender idling, main process only
  int unsigned sent_items = 0;     // bytes sent
  logic [7:0]  text_q [$];         // bytes of the buffer being built

  string word_pool [10] = '{"fn", "void", "number", "let", "var",
                            "if", "else", "while", "break", "return"};
  string op_pool   = "/()*+-,.:;{}=<>&";
  string pair_pool = "==<=>=&&";

  source_token_lexer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_kind    (out_token_kind),
    .out_token_start   (out_token_start),
    .out_token_length  (out_token_length),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_text   (out_end_of_text),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_emit_comments (cfg_emit_comments)
  );

  source_token_lexer_checker token_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_kind    (out_token_kind),
    .out_token_start   (out_token_start),
    .out_token_length  (out_token_length),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_text   (out_end_of_text),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_emit_comments (cfg_emit_comments),
    .pending_tokens    (tokens_pending),
    .mismatch_count    (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost token ends up here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Token side. Random stall bursts between open stretches until steady is
  // set; once the random part starts it holds off in one long stall so the result
  // queue fills and in_stall must rise while bytes keep coming.
  initial begin : receiver
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && hold_phase) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // One byte transaction. Valid stays up until the transaction goes
  // through; the caller either offers the next byte or idles after it.
  // in_stall read right after the edge is its value at that edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender pause: wait until every owed token has come out, then let a
  // byte that produces nothing finish its way through the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // emit_comments is only written with the lexer idle
  task automatic write_comments(input logic on);
    drain();
    cfg_valid         <= 1'b1;
    cfg_emit_comments <= on;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // appends one byte to the buffer being built
  task automatic put_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) put_byte(s[k]);
  endtask

  // Sends the built buffer, final flag on its last byte.
  task automatic send_buffer();
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      sent_items++;
      send_byte(text_q[i], i == n - 1);
    end
    text_q.delete();
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  // Keywords whole, keywords one char short or long, or plain identifiers.
  task automatic add_word();
    string w;
    int    len;
    w = word_pool[$urandom_range(0, 9)];
    case ($urandom_range(0, 3))
      0, 1: queue_text(w);
      2: begin
        if ($urandom_range(0, 1) && w.len() > 1) queue_text(w.substr(0, w.len() - 2));
        else begin
          queue_text(w);
          put_byte($urandom_range(0, 1) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
        end
      end
      default: begin
        len = $urandom_range(1, 9);
        put_byte(rand_letter());
        for (int i = 1; i < len; i++)
          put_byte($urandom_range(0, 2) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
      end
    endcase
  endtask

  // digits, optional dot, optional fraction digits (possibly none)
  task automatic add_number();
    repeat ($urandom_range(1, 5)) put_byte(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 1)) begin
      put_byte(".");
      repeat ($urandom_range(0, 3)) put_byte(8'("0" + $urandom_range(0, 9)));
    end
  endtask

  task automatic add_operator();
    int p;
    if ($urandom_range(0, 2) == 0) begin
      p = 2 * $urandom_range(0, 3);
      put_byte(pair_pool[p]);
      put_byte(pair_pool[p + 1]);
    end else put_byte(op_pool[$urandom_range(0, op_pool.len() - 1)]);
  endtask

  task automatic add_comment();
    queue_text("//");
    repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(32, 126)));
    if ($urandom_range(0, 1)) put_byte(8'h0A);
  endtask

  // Mostly well-formed token text, sometimes abutting tokens (which makes
  // broken pairs like "=<" or "12.5x"), and one buffer in ten pure noise.
  task automatic build_buffer();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3: add_word();
          4, 5:       add_number();
          6, 7, 8:    add_operator();
          9:          add_comment();
          default:    put_byte(8'($urandom_range(0, 255)));
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: put_byte(" ");
          4:          put_byte(8'h09);
          5:          put_byte(8'h0A);
          6:          put_byte(8'h0D);
          default: ;
        endcase
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corner buffers ----
    write_comments(1'b0);
    // byte extremes as invalid chars, then a number ending in a bare dot
    put_byte(8'h00);
    put_byte(8'hFF);
    queue_text("12.");
    send_buffer();
    // pending '=' has no second byte: identifier and '=' both on the last byte
    queue_text("a=");
    send_buffer();
    // nothing left at the end: end marker one past the last byte
    queue_text(" ");
    send_buffer();
    // comment dropped while emit_comments is off, then a paired operator
    queue_text("//x\n&&");
    send_buffer();
    write_comments(1'b1);
    // open comment flushed at the end of text
    queue_text("//y");
    send_buffer();
    queue_text("/");
    send_buffer();

    // ---- random text in four configuration phases ----
    for (int phase = 0; phase < 4; phase++) begin
      write_comments(phase % 2 == 0);
      if (phase == 0) hold_phase <= 1'b1;
      while (sent_items < (phase + 1) * TOKEN_GOAL / 4 + 20) begin
        if (gaps_on && sent_items >= TOKEN_GOAL - QUIET_TAIL) begin
          gaps_on = 1'b0;
          steady <= 1'b1;
        end
        build_buffer();
        send_buffer();
      end
    end

    drain();
    if (mismatches == 0 && tokens_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== source_token_lexer_unit.f =====
rtl/core/stl_pkg.sv
rtl/core/stl_lexer.sv
rtl/core/stl_fifo.sv
rtl/core/source_token_lexer_unit.sv
tb/source_token_lexer_checker.sv
tb/source_token_lexer_unit_test.sv
